/* rtl/core/qslp_pkg.sv */
// Shared types and constants for the quaternion slerp pipeline.
// Used by every module in rtl/core; depends on nothing else.
package qslp_pkg;

    // Q format of the quaternion components and of the internal angle/weight words.
    localparam int FRAC_BITS = 14;
    localparam int WF        = 30;
    localparam int COMP_W    = 16;
    localparam int BLEND_W   = 17;
    localparam int EPS_W     = 15;

    localparam int IN_BYTES_W = 152;
    localparam int OUT_W      = 64;

    // Internal word widths.
    localparam int CORDIC_W = 34;
    localparam int ANG_W    = WF + 1;
    localparam int SQ_IN_W  = 2 * WF + 1;
    localparam int SQ_W     = 2 * WF + 2;
    localparam int SQ_STEPS = WF + 1;
    localparam int DIV_W    = WF + 3;

    localparam logic [ANG_W-1:0]  ONE_Q30   = ANG_W'(1) << WF;
    localparam logic [BLEND_W-1:0] BLEND_ONE = BLEND_W'(1) << 16;

    // atan(2^-i) in Q30, truncated.
    localparam logic [29:0] ATAN_TAB [0:31] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,
        30'd63,        30'd31,        30'd15,        30'd7,
        30'd3,         30'd1,         30'd0,         30'd0
    };

    // Everything an item carries alongside the trigonometry.
    typedef struct packed {
        logic [3:0][COMP_W-1:0] sq;
        logic [3:0][COMP_W-1:0] gq;
        logic [BLEND_W-1:0]     t;
        logic                   flip;
        logic                   lin;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

endpackage

/* rtl/core/qslp_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on qslp_pkg.
module qslp_sqrt import qslp_pkg::*; #(
    parameter int SW = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [SQ_IN_W-1:0]   n_in,
    input  logic [SW-1:0]        side_in,
    output logic                 out_valid,
    output logic [ANG_W-1:0]     root_out,
    output logic [SW-1:0]        side_out
);

    logic              vld_reg  [1:SQ_STEPS];
    logic [SQ_W-1:0]   n_reg    [1:SQ_STEPS];
    logic [SQ_W-1:0]   res_reg  [1:SQ_STEPS];
    logic [SW-1:0]     side_reg [1:SQ_STEPS];

    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_stage
        localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * WF - 2 * i);
        logic            vi;
        logic [SQ_W-1:0] ni, ri, sum;
        logic [SW-1:0]   pi;
        logic            take;

        if (i == 0) begin : g_first
            assign vi = in_valid;
            assign ni = {1'b0, n_in};
            assign ri = '0;
            assign pi = side_in;
        end else begin : g_next
            assign vi = vld_reg[i];
            assign ni = n_reg[i];
            assign ri = res_reg[i];
            assign pi = side_reg[i];
        end

        assign sum  = ri + BITV;
        assign take = (ni >= sum);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vi;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[i+1]    <= take ? ni - sum : ni;
                res_reg[i+1]  <= take ? (ri >> 1) + BITV : ri >> 1;
                side_reg[i+1] <= pi;
            end
        end
    end

    assign out_valid = vld_reg[SQ_STEPS];
    assign root_out  = res_reg[SQ_STEPS][ANG_W-1:0];
    assign side_out  = side_reg[SQ_STEPS];

endmodule

/* rtl/core/qslp_cordic.sv */
// Pipelined CORDIC, one micro-rotation per stage, in vectoring or rotation mode.
// Depends on qslp_pkg for the arctangent table and word width.
module qslp_cordic import qslp_pkg::*; #(
    parameter int STEPS     = 16,
    parameter int SW        = 8,
    parameter bit VECTORING = 1'b0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [CORDIC_W-1:0] x_in,
    input  logic signed [CORDIC_W-1:0] y_in,
    input  logic signed [CORDIC_W-1:0] z_in,
    input  logic [SW-1:0]              side_in,
    output logic                       out_valid,
    output logic signed [CORDIC_W-1:0] x_out,
    output logic signed [CORDIC_W-1:0] y_out,
    output logic signed [CORDIC_W-1:0] z_out,
    output logic [SW-1:0]              side_out
);

    logic                       vld_reg  [1:STEPS];
    logic signed [CORDIC_W-1:0] x_reg    [1:STEPS];
    logic signed [CORDIC_W-1:0] y_reg    [1:STEPS];
    logic signed [CORDIC_W-1:0] z_reg    [1:STEPS];
    logic [SW-1:0]              side_reg [1:STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        localparam int K = i % 32;
        localparam logic signed [CORDIC_W-1:0] AT =
            $signed({{(CORDIC_W-30){1'b0}}, ATAN_TAB[K]});
        logic                       vi, sub;
        logic signed [CORDIC_W-1:0] xi, yi, zi, xs, ys;
        logic [SW-1:0]              pi;

        if (i == 0) begin : g_first
            assign vi = in_valid;
            assign xi = x_in;
            assign yi = y_in;
            assign zi = z_in;
            assign pi = side_in;
        end else begin : g_next
            assign vi = vld_reg[i];
            assign xi = x_reg[i];
            assign yi = y_reg[i];
            assign zi = z_reg[i];
            assign pi = side_reg[i];
        end

        assign xs = xi >>> K;
        assign ys = yi >>> K;
        // Vectoring drives y toward zero, rotation drives z toward zero.
        assign sub = VECTORING ? !(yi > 0) : (zi >= 0);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vi;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i+1]    <= sub ? xi - ys : xi + ys;
                y_reg[i+1]    <= sub ? yi + xs : yi - xs;
                z_reg[i+1]    <= sub ? zi - AT : zi + AT;
                side_reg[i+1] <= pi;
            end
        end
    end

    assign out_valid = vld_reg[STEPS];
    assign x_out     = x_reg[STEPS];
    assign y_out     = y_reg[STEPS];
    assign z_out     = z_reg[STEPS];
    assign side_out  = side_reg[STEPS];

endmodule

/* rtl/core/qslp_div.sv */
// Pipelined restoring divider that forms a Q30 weight sin(a)/sin(omega),
// clamped to [0, 1.0]. Depends on qslp_pkg.
module qslp_div import qslp_pkg::*; #(
    parameter int SW = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [CORDIC_W-1:0] num_in,
    input  logic signed [CORDIC_W-1:0] den_in,
    input  logic [SW-1:0]              side_in,
    output logic                       out_valid,
    output logic [ANG_W-1:0]           w_out,
    output logic [SW-1:0]              side_out
);

    logic             vld_reg  [1:WF];
    logic [DIV_W-1:0] rem_reg  [1:WF];
    logic [DIV_W-1:0] den_reg  [1:WF];
    logic [WF-1:0]    q_reg    [1:WF];
    logic             pos_reg  [1:WF];
    logic             sat_reg  [1:WF];
    logic [SW-1:0]    side_reg [1:WF];

    // A non-positive numerator gives zero; a numerator at or above the
    // denominator gives the full-scale weight.
    logic pos0, sat0;
    assign pos0 = (num_in > 0);
    assign sat0 = (num_in >= den_in);

    for (genvar i = 0; i < WF; i++) begin : g_stage
        logic             vi, pi_pos, pi_sat, ge;
        logic [DIV_W-1:0] ri, di;
        logic [DIV_W:0]   r2;
        logic [WF-1:0]    qi;
        logic [SW-1:0]    pi;

        if (i == 0) begin : g_first
            assign vi     = in_valid;
            assign ri     = num_in[DIV_W-1:0];
            assign di     = den_in[DIV_W-1:0];
            assign qi     = '0;
            assign pi_pos = pos0;
            assign pi_sat = sat0;
            assign pi     = side_in;
        end else begin : g_next
            assign vi     = vld_reg[i];
            assign ri     = rem_reg[i];
            assign di     = den_reg[i];
            assign qi     = q_reg[i];
            assign pi_pos = pos_reg[i];
            assign pi_sat = sat_reg[i];
            assign pi     = side_reg[i];
        end

        assign r2 = {ri, 1'b0};
        assign ge = (r2 >= {1'b0, di});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vi;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1]  <= ge ? DIV_W'(r2 - {1'b0, di}) : r2[DIV_W-1:0];
                den_reg[i+1]  <= di;
                q_reg[i+1]    <= {qi[WF-2:0], ge};
                pos_reg[i+1]  <= pi_pos;
                sat_reg[i+1]  <= pi_sat;
                side_reg[i+1] <= pi;
            end
        end
    end

    assign out_valid = vld_reg[WF];
    assign w_out     = !pos_reg[WF] ? '0 :
                       sat_reg[WF]  ? ONE_Q30 : {1'b0, q_reg[WF]};
    assign side_out  = side_reg[WF];

endmodule

/* rtl/core/quaternion_slerp_unit.sv */
// Top level of the quaternion slerp pipeline: dot product, square root, CORDIC
// angle and sines, weight division and the weighted sum. Depends on qslp_pkg,
// qslp_sqrt, qslp_cordic and qslp_div.
//
// The unit takes one quaternion pair and blend factor per cycle while the output
// is not stalled, and returns one interpolated quaternion per item, in order. The
// pipeline is a chain of bit-serial stages: 31 square-root stages, two CORDIC
// passes of CORDIC_STEPS stages each and 30 divider stages. The whole pipeline
// advances together; it holds while the output item waits and m_tready is low.
// near_epsilon resets to 1 and may be written through the cfg channel while no
// item is in flight.
module quaternion_slerp_unit import qslp_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // start_x, start_y, start_z, start_w, goal_x, goal_y, goal_z, goal_w, blend
    input  logic [IN_BYTES_W-1:0] s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // out_x, out_y, out_z, out_w
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [EPS_W-1:0]      cfg_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready
);

    localparam int SH_L = (2 * FRAC_BITS >= WF) ? 0 : WF - 2 * FRAC_BITS;
    localparam int SH_R = (2 * FRAC_BITS >= WF) ? 2 * FRAC_BITS - WF : 0;

    logic en;
    logic [EPS_W-1:0] eps_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_W'(1);
        end else if (cfg_valid) begin
            eps_reg <= cfg_data;
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage 1: unpack and form the four component products.
    item_t in_item;
    logic [BLEND_W-1:0] blend_raw;
    assign blend_raw = s_tdata[8*COMP_W +: BLEND_W];
    always_comb begin
        in_item      = '0;
        in_item.sq   = s_tdata[4*COMP_W-1:0];
        in_item.gq   = s_tdata[8*COMP_W-1:4*COMP_W];
        in_item.t    = (blend_raw > BLEND_ONE) ? BLEND_ONE : blend_raw;
    end

    logic               v1_reg;
    item_t              it1_reg;
    logic signed [31:0] prod_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it1_reg <= in_item;
            for (int j = 0; j < 4; j++) begin
                prod_reg[j] <= $signed(in_item.sq[j]) * $signed(in_item.gq[j]);
            end
        end
    end

    // Stage 2: dot product, near test and cosine in Q30.
    logic signed [33:0] dot;
    logic [33:0]        cabs;
    logic signed [35:0] thr;
    logic [63:0]        cw_wide;
    logic [ANG_W-1:0]   cw;
    item_t              it2;

    assign dot  = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]) + 34'(prod_reg[3]);
    assign cabs = dot[33] ? 34'(-dot) : dot;
    assign thr  = $signed(36'(1) << (2 * FRAC_BITS)) - $signed(36'({eps_reg, {FRAC_BITS{1'b0}}}));
    assign cw_wide = ({30'b0, cabs} << SH_L) >> SH_R;
    assign cw   = (cw_wide > 64'(ONE_Q30)) ? ONE_Q30 : cw_wide[ANG_W-1:0];

    always_comb begin
        it2      = it1_reg;
        it2.flip = dot[33];
        it2.lin  = ($signed({2'b0, cabs}) > thr);
    end

    logic             v2_reg;
    item_t            it2_reg;
    logic [ANG_W-1:0] cw2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it2_reg <= it2;
            cw2_reg <= cw;
        end
    end

    // Stage 3: square of the cosine.
    logic               v3_reg;
    item_t              it3_reg;
    logic [ANG_W-1:0]   cw3_reg;
    logic [2*ANG_W-1:0] cwsq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it3_reg  <= it2_reg;
            cw3_reg  <= cw2_reg;
            cwsq_reg <= cw2_reg * cw2_reg;
        end
    end

    // Sine of omega from sqrt(1 - c^2).
    logic [SQ_IN_W-1:0] sq_n;
    assign sq_n = SQ_IN_W'((SQ_IN_W'(1) << (2 * WF)) - cwsq_reg[SQ_IN_W-1:0]);

    logic               sq_v;
    logic [ANG_W-1:0]   sq_root;
    logic [ITEM_W+ANG_W-1:0] sq_side;

    qslp_sqrt #(.SW(ITEM_W + ANG_W)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .n_in      (sq_n),
        .side_in   ({cw3_reg, it3_reg}),
        .out_valid (sq_v),
        .root_out  (sq_root),
        .side_out  (sq_side)
    );

    // Omega = atan2(s, c).
    item_t it_sq;
    always_comb begin
        it_sq     = item_t'(sq_side[ITEM_W-1:0]);
        it_sq.lin = it_sq.lin || (sq_root == '0);
    end

    logic                       at_v;
    logic signed [CORDIC_W-1:0] at_z;
    logic [ITEM_W-1:0]          at_side;

    qslp_cordic #(.STEPS(CORDIC_STEPS), .SW(ITEM_W), .VECTORING(1'b1)) u_atan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_v),
        .x_in      ($signed({3'b0, sq_side[ITEM_W +: ANG_W]})),
        .y_in      ($signed({3'b0, sq_root})),
        .z_in      ('0),
        .side_in   (it_sq),
        .out_valid (at_v),
        .x_out     (),
        .y_out     (),
        .z_out     (at_z),
        .side_out  (at_side)
    );

    // Stage A: clamp omega and scale it by 1-t and t.
    item_t            at_item;
    logic [ANG_W-1:0] omega;
    logic [47:0]      a1_wide, a2_wide;

    assign at_item = item_t'(at_side);
    assign omega   = at_z[CORDIC_W-1] ? '0 : at_z[ANG_W-1:0];
    assign a1_wide = (BLEND_ONE - at_item.t) * omega;
    assign a2_wide = at_item.t * omega;

    logic             va_reg;
    item_t            ita_reg;
    logic [ANG_W-1:0] om_reg, a1_reg, a2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= at_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ita_reg <= at_item;
            om_reg  <= omega;
            a1_reg  <= a1_wide[16 +: ANG_W];
            a2_reg  <= a2_wide[16 +: ANG_W];
        end
    end

    // Three sines side by side; the first carries the item.
    localparam logic signed [CORDIC_W-1:0] X_START = $signed({3'b0, ONE_Q30});

    logic                       sn_v;
    logic signed [CORDIC_W-1:0] den_y, num1_y, num2_y;
    logic [ITEM_W-1:0]          sn_side;

    qslp_cordic #(.STEPS(CORDIC_STEPS), .SW(ITEM_W), .VECTORING(1'b0)) u_sin_om (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (va_reg),
        .x_in      (X_START),
        .y_in      ('0),
        .z_in      ($signed({3'b0, om_reg})),
        .side_in   (ita_reg),
        .out_valid (sn_v),
        .x_out     (),
        .y_out     (den_y),
        .z_out     (),
        .side_out  (sn_side)
    );

    qslp_cordic #(.STEPS(CORDIC_STEPS), .SW(1), .VECTORING(1'b0)) u_sin_a1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (va_reg),
        .x_in      (X_START),
        .y_in      ('0),
        .z_in      ($signed({3'b0, a1_reg})),
        .side_in   (1'b0),
        .out_valid (),
        .x_out     (),
        .y_out     (num1_y),
        .z_out     (),
        .side_out  ()
    );

    qslp_cordic #(.STEPS(CORDIC_STEPS), .SW(1), .VECTORING(1'b0)) u_sin_a2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (va_reg),
        .x_in      (X_START),
        .y_in      ('0),
        .z_in      ($signed({3'b0, a2_reg})),
        .side_in   (1'b0),
        .out_valid (),
        .x_out     (),
        .y_out     (num2_y),
        .z_out     (),
        .side_out  ()
    );

    // A non-positive sin(omega) falls back to linear weights.
    item_t it_sn;
    always_comb begin
        it_sn     = item_t'(sn_side);
        it_sn.lin = it_sn.lin || (den_y <= 0);
    end

    logic              dv_v;
    logic [ANG_W-1:0]  w1_sph, w2_sph;
    logic [ITEM_W-1:0] dv_side;

    qslp_div #(.SW(ITEM_W)) u_div1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sn_v),
        .num_in    (num1_y),
        .den_in    (den_y),
        .side_in   (it_sn),
        .out_valid (dv_v),
        .w_out     (w1_sph),
        .side_out  (dv_side)
    );

    qslp_div #(.SW(1)) u_div2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sn_v),
        .num_in    (num2_y),
        .den_in    (den_y),
        .side_in   (1'b0),
        .out_valid (),
        .w_out     (w2_sph),
        .side_out  ()
    );

    // Stage O1: pick the weights and form the eight weighted components.
    item_t              dv_item;
    logic [ANG_W-1:0]   w1_sel, w2_sel;
    logic signed [31:0] w1_s, w2_s;

    assign dv_item = item_t'(dv_side);
    assign w1_sel  = dv_item.lin ? {(BLEND_ONE - dv_item.t), {(WF-16){1'b0}}} : w1_sph;
    assign w2_sel  = dv_item.lin ? {dv_item.t, {(WF-16){1'b0}}} : w2_sph;
    assign w1_s    = $signed({1'b0, w1_sel});
    assign w2_s    = dv_item.flip ? -$signed({1'b0, w2_sel}) : $signed({1'b0, w2_sel});

    logic               vo_reg;
    logic signed [47:0] ps_reg [4];
    logic signed [47:0] pg_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= dv_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                ps_reg[j] <= 48'(w1_s * $signed(dv_item.sq[j]));
                pg_reg[j] <= 48'(w2_s * $signed(dv_item.gq[j]));
            end
        end
    end

    // Stage O2: round half up, saturate and hold the output item.
    logic [OUT_W-1:0] out_next;
    always_comb begin
        logic signed [48:0] acc;
        logic signed [18:0] r;
        out_next = '0;
        for (int j = 0; j < 4; j++) begin
            acc = 49'(ps_reg[j]) + 49'(pg_reg[j]) + $signed(49'(1) << (WF - 1));
            r   = 19'(acc >>> WF);
            if (r > 19'sd32767) begin
                out_next[j*COMP_W +: COMP_W] = 16'h7fff;
            end else if (r < -19'sd32768) begin
                out_next[j*COMP_W +: COMP_W] = 16'h8000;
            end else begin
                out_next[j*COMP_W +: COMP_W] = r[COMP_W-1:0];
            end
        end
    end

    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= out_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* rtl/core/qslp_checker.sv */
// Port-level checks for quaternion_slerp_unit, attached by the bind below.
// Depends on qslp_pkg and the top level's port list.
module qslp_checker import qslp_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic [OUT_W-1:0]      m_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready
);

    // A waiting output item stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    // The pipeline only stops taking items when the output stage is full.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind quaternion_slerp_unit qslp_checker u_qslp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
